>>> hdl/rct_pkg.sv
// rct_pkg: shared types and constants for the red object centroid tracker
// used by rct_div, red_object_centroid_tracker_top and tb; no dependencies
`default_nettype none

package rct_pkg;

    // fixed field widths
    localparam int COLOR_W  = 8;
    localparam int FW_W     = 11;
    localparam int MARGIN_W = 8;
    localparam int SUM_W    = 30;
    localparam int CNT_W    = 21;
    localparam int CENT_W   = 14;

    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CENT_W-1:0] CENT_MAX  = {CENT_W{1'b1}};

    localparam logic [FW_W-1:0]     FW_RESET     = 11'd640;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd100;

    // register index, taken from paddr[2]
    localparam logic REG_FRAME_WIDTH = 1'b0;
    localparam logic REG_RED_MARGIN  = 1'b1;

    // parameter defaults
    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_MAX_HEIGHT    = 1024;
    localparam int DEF_FRACTION_BITS = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_X,
        ST_WAIT_X,
        ST_START_Y,
        ST_WAIT_Y
    } seq_state_t;

endpackage

`default_nettype wire

>>> hdl/red_object_centroid_tracker_top.sv
// red_object_centroid_tracker_top: red pixel mask, coordinate sums and
// per-frame centroid; depends on rct_pkg and rct_div
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  pixel in | in  | in_valid/in_ready  | red, green, blue, end_of_frame
//  result   | out | out_valid/out_ready| pixel_mask, frame_done, centroid_x/y, red_count
//  config   | in  | apb, pready high   | 0x0 frame_width, 0x4 red_margin
//
// a pixel without end_of_frame streams at one per clock while results are taken
// the end_of_frame pixel starts the shared restoring divider, which works out
// x then y, one quotient bit per cycle; input stalls until both are done
// rst_n clears counters, sums, state and out_valid and resets config at once
// input also stalls while the result register holds a beat not yet taken
`default_nettype none

module red_object_centroid_tracker_top #(
    parameter int MAX_WIDTH     = rct_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = rct_pkg::DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = rct_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // pixel in
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [rct_pkg::COLOR_W-1:0] red,
    input  wire logic [rct_pkg::COLOR_W-1:0] green,
    input  wire logic [rct_pkg::COLOR_W-1:0] blue,
    input  wire logic                        end_of_frame,
    // result
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             pixel_mask,
    output logic                             frame_done,
    output logic [rct_pkg::CENT_W-1:0]       centroid_x,
    output logic [rct_pkg::CENT_W-1:0]       centroid_y,
    output logic [rct_pkg::CNT_W-1:0]        red_count,
    // config
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rct_pkg::APB_AW-1:0]  paddr,
    input  wire logic [rct_pkg::APB_DW-1:0]  pwdata,
    output logic [rct_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);
    import rct_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CMP_W = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;

    // configuration
    logic [FW_W-1:0]     fw_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic                cfg_wr;

    // frame state
    seq_state_t       state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [SUM_W-1:0] sx_reg, sx_next;
    logic [SUM_W-1:0] sy_reg, sy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // finished frame totals for the divider
    logic [SUM_W-1:0] fsx_reg, fsx_next;
    logic [SUM_W-1:0] fsy_reg, fsy_next;
    logic [CNT_W-1:0] fcnt_reg, fcnt_next;

    // result register
    logic              ov_reg, ov_next;
    logic              mask_reg, mask_next;
    logic              done_reg, done_next;
    logic [CENT_W-1:0] cx_reg, cx_next;
    logic [CENT_W-1:0] cy_reg, cy_next;
    logic [CNT_W-1:0]  rc_reg, rc_next;

    logic              accept;
    logic              hit;
    logic [COLOR_W:0]  g_lim, b_lim;
    logic [CMP_W-1:0]  width_eff;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [SUM_W:0]    sx_add, sy_add;
    logic [SUM_W-1:0]  sx_acc, sy_acc;
    logic [CNT_W-1:0]  cnt_acc;
    logic [SUM_W-1:0]  div_sum;
    logic [CENT_W-1:0] div_q;
    logic              div_start;
    logic              div_done;

    // apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_FRAME_WIDTH) ? APB_DW'(fw_reg) : APB_DW'(margin_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg     <= FW_RESET;
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_FRAME_WIDTH)
                fw_reg <= pwdata[FW_W-1:0];
            else
                margin_reg <= pwdata[MARGIN_W-1:0];
        end
    end

    // classification and accumulation
    assign in_ready = (state_reg == ST_IDLE) && (!ov_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign g_lim = {1'b0, green} + {1'b0, margin_reg};
    assign b_lim = {1'b0, blue} + {1'b0, margin_reg};
    assign hit   = ({1'b0, red} > g_lim) && ({1'b0, red} > b_lim);

    assign sx_add  = {1'b0, sx_reg} + (SUM_W + 1)'(col_reg);
    assign sy_add  = {1'b0, sy_reg} + (SUM_W + 1)'(row_reg);
    assign sx_acc  = !hit ? sx_reg : (sx_add[SUM_W] ? SUM_MAX : sx_add[SUM_W-1:0]);
    assign sy_acc  = !hit ? sy_reg : (sy_add[SUM_W] ? SUM_MAX : sy_add[SUM_W-1:0]);
    assign cnt_acc = (hit && (cnt_reg != CNT_MAX)) ? cnt_reg + 1'b1 : cnt_reg;

    assign width_eff = ((fw_reg == '0) || (CMP_W'(fw_reg) > CMP_W'(MAX_WIDTH)))
                       ? CMP_W'(MAX_WIDTH) : CMP_W'(fw_reg);
    assign col_inc   = {1'b0, col_reg} + 1'b1;
    assign row_inc   = {1'b0, row_reg} + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        cnt_next   = cnt_reg;
        fsx_next   = fsx_reg;
        fsy_next   = fsy_reg;
        fcnt_next  = fcnt_reg;
        ov_next    = ov_reg && !out_ready;
        mask_next  = mask_reg;
        done_next  = done_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        rc_next    = rc_reg;
        div_start  = 1'b0;
        div_sum    = fsx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mask_next = hit;
                    if (end_of_frame)
                    begin
                        fsx_next   = sx_acc;
                        fsy_next   = sy_acc;
                        fcnt_next  = cnt_acc;
                        col_next   = '0;
                        row_next   = '0;
                        sx_next    = '0;
                        sy_next    = '0;
                        cnt_next   = '0;
                        state_next = ST_START_X;
                    end
                    else
                    begin
                        sx_next   = sx_acc;
                        sy_next   = sy_acc;
                        cnt_next  = cnt_acc;
                        ov_next   = 1'b1;
                        done_next = 1'b0;
                        cx_next   = '0;
                        cy_next   = '0;
                        rc_next   = '0;
                        if (CMP_W'(col_inc) >= width_eff)
                        begin
                            col_next = '0;
                            if (row_inc < (ROW_W + 1)'(MAX_HEIGHT))
                                row_next = row_inc[ROW_W-1:0];
                        end
                        else
                        begin
                            col_next = col_inc[COL_W-1:0];
                        end
                    end
                end
            end
            ST_START_X:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT_X;
            end
            ST_WAIT_X:
            begin
                if (div_done)
                begin
                    cx_next    = (fcnt_reg == '0) ? '0 : div_q;
                    state_next = ST_START_Y;
                end
            end
            ST_START_Y:
            begin
                div_start  = 1'b1;
                div_sum    = fsy_reg;
                state_next = ST_WAIT_Y;
            end
            ST_WAIT_Y:
            begin
                if (div_done)
                begin
                    cy_next    = (fcnt_reg == '0) ? '0 : div_q;
                    rc_next    = fcnt_reg;
                    done_next  = 1'b1;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    rct_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .sum      (div_sum),
        .count    (fcnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fsx_reg  <= fsx_next;
        fsy_reg  <= fsy_next;
        fcnt_reg <= fcnt_next;
        mask_reg <= mask_next;
        done_reg <= done_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        rc_reg   <= rc_next;
    end

    assign out_valid  = ov_reg;
    assign pixel_mask = mask_reg;
    assign frame_done = done_reg;
    assign centroid_x = cx_reg;
    assign centroid_y = cy_reg;
    assign red_count  = rc_reg;

endmodule

`default_nettype wire

>>> hdl/rct_div.sv
// rct_div: restoring divider, one quotient bit per cycle, saturating result
// depends on rct_pkg
`default_nettype none

module rct_div #(
    parameter int FRACTION_BITS = rct_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [rct_pkg::SUM_W-1:0] sum,
    input  wire logic [rct_pkg::CNT_W-1:0] count,
    output logic                           done,
    output logic [rct_pkg::CENT_W-1:0]     quotient
);
    import rct_pkg::*;

    localparam int DIV_W   = SUM_W + FRACTION_BITS;
    localparam int STEP_W  = $clog2(DIV_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg,  rem_next;
    logic [DIV_W-1:0]  quo_reg,  quo_next;
    logic [CNT_W-1:0]  dsr_reg,  dsr_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;

    // one shift, compare and subtract per cycle
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_W);
            rem_next  = '0;
            quo_next  = DIV_W'(sum) << FRACTION_BITS;
            dsr_next  = count;
        end
        else if (busy_reg)
        begin
            if (!diff[CNT_W])
            begin
                rem_next = diff[CNT_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = (|quo_reg[DIV_W-1:CENT_W]) ? CENT_MAX : quo_reg[CENT_W-1:0];

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for red_object_centroid_tracker_top; streams pixels,
// tracks mask, coordinate sums and per-frame centroid on its own side
// depends on rct_pkg and the top level rtl

module tb;
    import rct_pkg::*;

    localparam int MAX_W     = DEF_MAX_WIDTH;
    localparam int MAX_H     = DEF_MAX_HEIGHT;
    localparam int FRAC      = DEF_FRACTION_BITS;
    localparam int POS_W     = $clog2(MAX_W);
    localparam int LONG_HOLD = 300;
    // end of frame runs the divider twice
    localparam int SETTLE    = 2 * (SUM_W + FRAC) + 6;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               eof;
    } pixel_t;

    typedef struct packed {
        logic              mask;
        logic              done;
        logic [CENT_W-1:0] cx;
        logic [CENT_W-1:0] cy;
        logic [CNT_W-1:0]  count;
    } track_result_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic [COLOR_W-1:0] red          = '0;
    logic [COLOR_W-1:0] green        = '0;
    logic [COLOR_W-1:0] blue         = '0;
    logic               end_of_frame = 1'b0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic               pixel_mask;
    logic               frame_done;
    logic [CENT_W-1:0]  centroid_x;
    logic [CENT_W-1:0]  centroid_y;
    logic [CNT_W-1:0]   red_count;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [APB_AW-1:0]  paddr        = '0;
    logic [APB_DW-1:0]  pwdata       = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    red_object_centroid_tracker_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .end_of_frame (end_of_frame),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_mask   (pixel_mask),
        .frame_done   (frame_done),
        .centroid_x   (centroid_x),
        .centroid_y   (centroid_y),
        .red_count    (red_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // tracker state kept on the bench side
    logic [FW_W-1:0]     cfg_width  = FW_RESET;
    logic [MARGIN_W-1:0] cfg_margin = MARGIN_RESET;
    logic [POS_W-1:0]    pos_col    = '0;
    logic [POS_W-1:0]    pos_row    = '0;
    logic [SUM_W-1:0]    sum_col    = '0;
    logic [SUM_W-1:0]    sum_row    = '0;
    logic [CNT_W-1:0]    hits       = '0;

    pixel_t        pixel_q[$];
    track_result_t tracked_q[$];
    pixel_t        next_px;
    track_result_t got;
    track_result_t want;

    bit idle_on     = 1'b1;
    int gap_left    = 0;
    int stall_left  = 0;
    int rx_gap      = 0;
    int hold_left   = 0;
    int holds_asked = 0;
    int holds_done  = 0;
    int beats       = 0;
    int mismatches  = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("tb failed");
        $finish;
    end

    function automatic int idle_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [POS_W-1:0] v);
        longint unsigned s;
        s = acc;
        s = s + v;
        return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic logic [CENT_W-1:0] mean_fixed(logic [SUM_W-1:0] sum,
                                                     logic [CNT_W-1:0] n);
        longint unsigned q;
        if (n == 0)
            return '0;
        q = sum;
        q = (q << FRAC) / n;
        return (q > CENT_MAX) ? CENT_MAX : q[CENT_W-1:0];
    endfunction

    function automatic track_result_t track_pixel(pixel_t px);
        track_result_t res;
        int            eff_width;
        logic          hit;
        eff_width = (cfg_width == 0 || cfg_width > MAX_W) ? MAX_W : int'(cfg_width);
        hit = (int'(px.red) > int'(px.green) + int'(cfg_margin))
           && (int'(px.red) > int'(px.blue) + int'(cfg_margin));
        res = '0;
        res.mask = hit;
        if (hit)
        begin
            sum_col = sat_sum(sum_col, pos_col);
            sum_row = sat_sum(sum_row, pos_row);
            if (hits != CNT_MAX)
                hits = hits + 1'b1;
        end
        if (px.eof)
        begin
            res.done  = 1'b1;
            res.cx    = mean_fixed(sum_col, hits);
            res.cy    = mean_fixed(sum_row, hits);
            res.count = hits;
            pos_col   = '0;
            pos_row   = '0;
            sum_col   = '0;
            sum_row   = '0;
            hits      = '0;
        end
        else if (int'(pos_col) + 1 >= eff_width)
        begin
            pos_col = '0;
            // row sticks at the last one on a frame that is too tall
            if (int'(pos_row) + 1 < MAX_H)
                pos_row = pos_row + 1'b1;
        end
        else
            pos_col = pos_col + 1'b1;
        return res;
    endfunction

    task automatic flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    task automatic queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit eof);
        pixel_q.push_back({r, g, b, eof});
    endtask

    task automatic queue_random_pixel(bit eof);
        int kind;
        int g;
        int b;
        int lo;
        kind = $urandom_range(0, 9);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
        if (kind < 5)
        begin
            // keep green and blue low enough that red can still clear the margin
            g  = $urandom_range(0, 255 - cfg_margin);
            b  = $urandom_range(0, 255 - cfg_margin);
            lo = ((g > b) ? g : b) + cfg_margin;
            if (kind < 4)
                lo = lo + 1 + $urandom_range(0, 1) * $urandom_range(0, 80);
            else
                lo = lo + $urandom_range(0, 1);   // just under or just over
            queue_pixel((lo > 255) ? 8'd255 : lo[7:0], g[7:0], b[7:0], eof);
        end
        else
            queue_pixel(8'($urandom_range(0, 255)), g[7:0], b[7:0], eof);
    endtask

    task automatic queue_random_items(int n);
        for (int i = 0; i < n; i++)
            queue_random_pixel($urandom_range(0, 24) == 0);
    endtask

    task automatic queue_frame(int len);
        for (int i = 0; i < len; i++)
            queue_random_pixel(i == len - 1);
    endtask

    // sampled away from the rising edge so the sender and monitor have settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixel_q.size() != 0 || in_valid || tracked_q.size() != 0);
    endtask

    task automatic apb_cycle(bit wr, logic [APB_AW-1:0] addr, logic [APB_DW-1:0] wdata,
                             output logic [APB_DW-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_register(logic idx, int value);
        logic [APB_DW-1:0] wdata;
        logic [APB_DW-1:0] stored;
        logic [APB_DW-1:0] readback;
        logic [APB_AW-1:0] addr;
        // junk in the unused upper bits
        wdata  = $urandom;
        stored = '0;
        addr   = {idx, 2'b00};
        if (idx == REG_FRAME_WIDTH)
        begin
            wdata[FW_W-1:0]  = value[FW_W-1:0];
            stored[FW_W-1:0] = value[FW_W-1:0];
            cfg_width        = value[FW_W-1:0];
        end
        else
        begin
            wdata[MARGIN_W-1:0]  = value[MARGIN_W-1:0];
            stored[MARGIN_W-1:0] = value[MARGIN_W-1:0];
            cfg_margin           = value[MARGIN_W-1:0];
        end
        apb_cycle(1'b1, addr, wdata, readback);
        apb_cycle(1'b0, addr, '0, readback);
        if (readback !== stored)
            flag_mismatch($sformatf("register at 0x%0h: want 0x%0h got 0x%0h",
                                    addr, stored, readback));
    endtask

    task automatic pick_setting(int p, output int w, output int m);
        case (p)
            0:       begin w = 2047; m = 255; end
            1:       begin w = 1025; m = 0;   end
            2:       begin w = 1024; m = 17;  end
            3:       begin w = 2;    m = 200; end
            4:       begin w = 3;    m = 1;   end
            5:       begin w = 7;    m = 64;  end
            6:       begin w = 33;   m = 128; end
            7:       begin w = 1;    m = 30;  end
            8:       begin w = 5;    m = 90;  end
            default: begin w = 640;  m = 100; end
        endcase
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!in_valid || in_ready)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pixel_q.size() != 0)
            begin
                next_px      = pixel_q.pop_front();
                red          <= next_px.red;
                green        <= next_px.green;
                blue         <= next_px.blue;
                end_of_frame <= next_px.eof;
                in_valid     <= 1'b1;
                gap_left     <= idle_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= (hold_left == 1);
        end
        else if (holds_done != holds_asked)
        begin
            holds_done <= holds_done + 1;
            hold_left  <= LONG_HOLD;
            out_ready  <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end
        else if (out_valid && out_ready)
        begin
            rx_gap = idle_gap();
            stall_left <= rx_gap;
            out_ready  <= (rx_gap == 0);
        end
        else
            out_ready <= 1'b1;
    end

    // check result beats, then predict for the pixel taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {pixel_mask, frame_done, centroid_x, centroid_y, red_count};
                beats++;
                if (tracked_q.size() == 0)
                    flag_mismatch($sformatf("beat %0d: result with no pixel outstanding",
                                            beats));
                else
                begin
                    want = tracked_q.pop_front();
                    if (got !== want)
                        flag_mismatch($sformatf(
                            "beat %0d: want %0b %0b x=%0d y=%0d n=%0d got %0b %0b x=%0d y=%0d n=%0d",
                            beats, want.mask, want.done, want.cx, want.cy, want.count,
                            got.mask, got.done, got.cx, got.cy, got.count));
                end
            end
            if (in_valid && in_ready)
                tracked_q.push_back(track_pixel({red, green, blue, end_of_frame}));
        end
    end

    initial
    begin
        int w;
        int m;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, back to back: margin edges, saturated colors, empty frame
        idle_on = 1'b0;
        queue_pixel(255, 0, 0, 0);
        queue_pixel(0, 0, 0, 0);
        queue_pixel(255, 255, 255, 0);
        queue_pixel(200, 100, 99, 0);
        queue_pixel(201, 100, 100, 0);
        queue_pixel(255, 154, 154, 0);
        queue_pixel(255, 155, 0, 0);
        queue_pixel(255, 0, 155, 0);
        queue_pixel(0, 255, 255, 0);
        queue_pixel(255, 0, 0, 1);
        queue_pixel(0, 0, 0, 1);
        queue_pixel(128, 0, 0, 1);
        queue_pixel(255, 0, 0, 0);
        queue_pixel(10, 20, 30, 1);
        queue_pixel(101, 0, 0, 0);
        queue_pixel(100, 0, 0, 1);
        wait_drained();

        // width 0 falls back to the widest row
        idle_on = 1'b1;
        set_register(REG_FRAME_WIDTH, 0);
        set_register(REG_RED_MARGIN, 40);
        queue_frame(40);
        queue_frame(5);
        wait_drained();

        for (int p = 0; p < 10; p++)
        begin
            pick_setting(p, w, m);
            set_register(REG_FRAME_WIDTH, w);
            set_register(REG_RED_MARGIN, m);
            idle_on = (p != 4);
            if (p == 2)
            begin
                // receiver holds off while pixels keep coming, input backs up
                idle_on = 1'b0;
                holds_asked++;
                queue_random_items(60);
                wait_drained();
                idle_on = 1'b1;
            end
            queue_random_items(42);
            // sender pauses until every result is back
            wait_drained();
            queue_random_items(42);
            wait_drained();
        end

        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && tracked_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

>>> red_object_centroid_tracker_top.f
hdl/rct_pkg.sv
hdl/rct_div.sv
hdl/red_object_centroid_tracker_top.sv
tb/sv/tb.sv
